### rtl/swmf_pkg.sv
// ----------------------------------------------------------------------------
// swmf_pkg: shared definitions for the sliding window median filter
// Default sizes and the status bundle that each sorted cell hands to its neighbors.
// ----------------------------------------------------------------------------
package swmf_pkg;

  localparam int unsigned WindowSizeDef  = 5;
  localparam int unsigned SampleWidthDef = 16;

  // Status of one cell toward the rest of the chain.
  typedef struct packed {
    logic gt;       // cell is empty or holds a value above the new sample
    logic del_out;  // the removed slot is at or below this cell
  } swmf_stat_t;

endpackage

### rtl/swmf_cell.sv
// ----------------------------------------------------------------------------
// swmf_cell: one slot of the sorted window
// Holds a sample and its age; on each request it keeps its value, takes a
// neighbor's value, or takes the new sample, so the row stays ascending.
// ----------------------------------------------------------------------------
module swmf_cell
  import swmf_pkg::*;
#(
  parameter int unsigned WINDOW_SIZE  = WindowSizeDef,
  parameter int unsigned SAMPLE_WIDTH = SampleWidthDef,
  parameter int unsigned IDX          = 0,
  localparam int unsigned AGE_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1,
  localparam int unsigned CNT_W = $clog2(WINDOW_SIZE + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           shift_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic        [CNT_W-1:0]        count_i,
  input  logic                           full_i,
  input  logic                           del_in_i,
  input  logic signed [SAMPLE_WIDTH-1:0] left_val_i,
  input  logic        [AGE_W-1:0]        left_age_i,
  input  logic                           left_gt_i,
  input  logic signed [SAMPLE_WIDTH-1:0] right_val_i,
  input  logic        [AGE_W-1:0]        right_age_i,
  input  logic                           right_gt_i,
  output logic signed [SAMPLE_WIDTH-1:0] val_o,
  output logic signed [SAMPLE_WIDTH-1:0] val_next_o,
  output logic        [AGE_W-1:0]        age_o,
  output swmf_stat_t                     stat_o
);

  logic signed [SAMPLE_WIDTH-1:0] val_q, val_d;
  logic        [AGE_W-1:0]        age_q, age_d;
  logic                           valid;
  logic                           del_here;
  logic                           gt;
  logic                           take_self;
  logic                           take_right;
  logic                           take_left;

  assign valid    = (CNT_W'(IDX) < count_i);
  // Drop the oldest sample when full, otherwise the first empty slot.
  assign del_here = full_i ? (age_q == AGE_W'(WINDOW_SIZE - 1))
                           : (count_i == CNT_W'(IDX));
  assign gt       = !valid || (val_q > sample_i);

  assign take_self  = (!del_in_i && !del_here && !gt) || (del_in_i && gt);
  assign take_right = (del_in_i || del_here) && !right_gt_i;
  assign take_left  = !del_in_i && left_gt_i;

  always_comb begin
    priority if (take_self) begin
      val_d = val_q;
      age_d = age_q + 1'b1;
    end else if (take_right) begin
      val_d = right_val_i;
      age_d = right_age_i + 1'b1;
    end else if (take_left) begin
      val_d = left_val_i;
      age_d = left_age_i + 1'b1;
    end else begin
      val_d = sample_i;
      age_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      val_q <= val_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_q <= '0;
    end else if (shift_i) begin
      age_q <= age_d;
    end
  end

  assign val_o          = val_q;
  assign val_next_o     = val_d;
  assign age_o          = age_q;
  assign stat_o.gt      = gt;
  assign stat_o.del_out = del_in_i || del_here;

endmodule

### rtl/sliding_window_median_filter.sv
// The median is registered: it appears in the output register in the cycle after its sample is accepted.
// Throughput: one sample per cycle while the output is not stalled; each request is one step of the cell row.
// The delete/insert decision ripples combinationally through the WINDOW_SIZE cells.
// Reset: clears the fill count, the cell ages and the output valid flag.
// ----------------------------------------------------------------------------
// sliding_window_median_filter: running median over the last samples
// A row of cells keeps the window sorted; each request removes the oldest
// (or fills an empty slot), inserts the new sample and reads the middle.
// ----------------------------------------------------------------------------
module sliding_window_median_filter
  import swmf_pkg::*;
#(
  parameter int unsigned WINDOW_SIZE  = WindowSizeDef,
  parameter int unsigned SAMPLE_WIDTH = SampleWidthDef,
  localparam int unsigned AGE_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1,
  localparam int unsigned CNT_W = $clog2(WINDOW_SIZE + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] median_o
);

  // Cell row wiring; each cell sees the outputs of its two neighbors.
  logic signed [SAMPLE_WIDTH-1:0] cell_val  [WINDOW_SIZE];
  logic signed [SAMPLE_WIDTH-1:0] cell_next [WINDOW_SIZE];
  logic        [AGE_W-1:0]        cell_age  [WINDOW_SIZE];
  swmf_stat_t                     cell_stat [WINDOW_SIZE];

  logic [CNT_W-1:0]               count_q, count_d;
  logic [CNT_W-1:0]               mid_idx;
  logic                           full;
  logic                           accept;
  logic                           out_valid_q, out_valid_d;
  logic signed [SAMPLE_WIDTH-1:0] median_q, median_d;
  logic                           sorted_ok;

  // Output register parts the two sides: take a new sample when the register is
  // empty or while the result is being taken in the same cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign full    = (count_q == CNT_W'(WINDOW_SIZE));
  assign count_d = full ? count_q : count_q + 1'b1;
  assign mid_idx = count_d >> 1;

  for (genvar i = 0; i < WINDOW_SIZE; i++) begin : g_cell
    logic signed [SAMPLE_WIDTH-1:0] l_val, r_val;
    logic        [AGE_W-1:0]        l_age, r_age;
    logic                           l_gt, r_gt, d_in;

    // Tie off the row ends: nothing below cell 0 moves up, and the slot
    // past the top behaves as an empty (infinite) entry.
    if (i == 0) begin : g_lo
      assign l_val = '0;
      assign l_age = '0;
      assign l_gt  = 1'b0;
      assign d_in  = 1'b0;
    end else begin : g_mid_lo
      assign l_val = cell_val[i-1];
      assign l_age = cell_age[i-1];
      assign l_gt  = cell_stat[i-1].gt;
      assign d_in  = cell_stat[i-1].del_out;
    end

    if (i == WINDOW_SIZE - 1) begin : g_hi
      assign r_val = '0;
      assign r_age = '0;
      assign r_gt  = 1'b1;
    end else begin : g_mid_hi
      assign r_val = cell_val[i+1];
      assign r_age = cell_age[i+1];
      assign r_gt  = cell_stat[i+1].gt;
    end

    swmf_cell #(
      .WINDOW_SIZE (WINDOW_SIZE),
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .IDX         (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (accept),
      .sample_i   (sample_i),
      .count_i    (count_q),
      .full_i     (full),
      .del_in_i   (d_in),
      .left_val_i (l_val),
      .left_age_i (l_age),
      .left_gt_i  (l_gt),
      .right_val_i(r_val),
      .right_age_i(r_age),
      .right_gt_i (r_gt),
      .val_o      (cell_val[i]),
      .val_next_o (cell_next[i]),
      .age_o      (cell_age[i]),
      .stat_o     (cell_stat[i])
    );
  end

  // Pick the middle of the updated row: index count/2 gives the upper
  // median for an even count.
  always_comb begin
    median_d = cell_next[0];
    for (int i = 0; i < WINDOW_SIZE; i++) begin
      if (mid_idx == CNT_W'(i)) begin
        median_d = cell_next[i];
      end
    end
  end

  assign out_valid_d = accept || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      median_q <= median_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign median_o    = median_q;

  // Occupied cells must stay in ascending order.
  always_comb begin
    sorted_ok = 1'b1;
    for (int i = 1; i < WINDOW_SIZE; i++) begin
      if ((CNT_W'(i) < count_q) && (cell_val[i-1] > cell_val[i])) begin
        sorted_ok = 1'b0;
      end
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(WINDOW_SIZE))
    else $error("fill count exceeds window size");

  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sorted_ok)
    else $error("cell row lost ascending order");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted sample produced no result");

  a_count_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !full) |=> (count_q == $past(count_q) + 1'b1))
    else $error("fill count did not advance");

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the sliding window median filter
// Streams signed samples through the filter with random request gaps and
// output stalls, and compares every median with a behavioral window model.
// ----------------------------------------------------------------------------
module testbench;
  import swmf_pkg::*;

  typedef logic signed [SampleWidthDef-1:0] sample_t;

  localparam int unsigned RandomFullCount    = 700;
  localparam int unsigned RandomClusterCount = 600;
  localparam int unsigned SettleCycles       = 10;

  logic    clk_i;
  logic    rst_ni;
  logic    in_valid;
  logic    in_ready_o;
  sample_t sample_in;
  logic    out_valid_o;
  logic    out_ready = 1'b0;
  sample_t median_o;

  // Behavioral window: ring of samples, next slot and fill count.
  sample_t     ring [WindowSizeDef];
  int unsigned ring_slot;
  int unsigned ring_fill;

  sample_t     expected_medians [$];
  int unsigned mismatch_count = 0;
  int unsigned burst_left;
  int unsigned cycle_count = 0;
  int unsigned stall_mode = 0;

  sliding_window_median_filter #(
    .WINDOW_SIZE  (WindowSizeDef),
    .SAMPLE_WIDTH (SampleWidthDef)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_in),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .median_o    (median_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

  // Write the sample into the ring and return the median of the filled slots.
  function automatic sample_t window_median(input sample_t value);
    sample_t     sorted [WindowSizeDef];
    sample_t     key;
    int unsigned i;
    int unsigned j;
    ring[ring_slot] = value;
    ring_slot = (ring_slot + 1 >= WindowSizeDef) ? 0 : ring_slot + 1;
    if (ring_fill < WindowSizeDef) ring_fill++;
    for (i = 0; i < ring_fill; i++) sorted[i] = ring[i];
    for (i = 1; i < ring_fill; i++) begin
      key = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > key) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = key;
    end
    return sorted[ring_fill / 2];
  endfunction

  // Receiver: drive out_ready from a stall pattern that is picked anew at random.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (cycle_count % 5 != 0);
    endcase
  end

  // Compare every accepted median with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) begin
      if (expected_medians.size() == 0) begin
        $display("%0t: unexpected median, expected none, actual %0d", $time, median_o);
        mismatch_count++;
      end else begin
        if (median_o !== expected_medians[0]) begin
          $display("%0t: median mismatch, expected %0d, actual %0d",
                   $time, expected_medians[0], median_o);
          mismatch_count++;
        end
        void'(expected_medians.pop_front());
      end
    end
  end

  // Send one request; hold it until accepted, then maybe drop valid for a gap.
  task automatic send_sample(input sample_t value);
    int unsigned gap;
    in_valid  <= 1'b1;
    sample_in <= value;
    do @(posedge clk_i); while (!in_ready_o);
    expected_medians.push_back(window_median(value));
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 150 : $urandom_range(1, 12);
    end
  endtask

  // Drop valid and hold off until every expected median has arrived.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (expected_medians.size() != 0);
  endtask

  // Fill phase with extremes: counts 1..5 cover odd and even upper medians.
  task automatic test_fill_extremes();
    send_sample(sample_t'(-32768));
    send_sample(sample_t'(32767));
    send_sample(sample_t'(0));
    send_sample(sample_t'(-1));
    send_sample(sample_t'(1));
  endtask

  // Equal samples across the whole window and overlapping ties.
  task automatic test_equal_values();
    repeat (5) send_sample(sample_t'(16'h1234));
    send_sample(sample_t'(-5));
    send_sample(sample_t'(-5));
  endtask

  // Ramps that wrap the ring more than once and evict the oldest sample.
  task automatic test_wrap_ramps();
    int i;
    for (i = 0; i < 6; i++) send_sample(sample_t'(i * 1000 - 2500));
    for (i = 0; i < 6; i++) send_sample(sample_t'(32767 - i * 7));
  endtask

  task automatic test_random_full_range();
    int unsigned n;
    for (n = 0; n < RandomFullCount; n++) begin
      send_sample(sample_t'($urandom));
      if (n == RandomFullCount / 2) wait_for_drain();
    end
  endtask

  // Values from narrow pools so that ties and extremes pile up in the window.
  task automatic test_random_clustered();
    int unsigned n;
    sample_t     value;
    for (n = 0; n < RandomClusterCount; n++) begin
      case ($urandom_range(0, 4))
        0: value = sample_t'(int'($urandom_range(0, 4)) - 2);
        1: value = $urandom_range(0, 1) ? sample_t'(32767) : sample_t'(-32768);
        2: value = sample_t'(32767 - int'($urandom_range(0, 3)));
        3: value = sample_t'(int'($urandom_range(0, 3)) - 32768);
        default: value = sample_t'($urandom);
      endcase
      send_sample(value);
      if (n % 200 == 199) wait_for_drain();
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid       = 1'b0;
    sample_in      = '0;
    ring_slot      = 0;
    ring_fill      = 0;
    burst_left     = $urandom_range(1, 12);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_fill_extremes();
    test_equal_values();
    test_wrap_ramps();
    test_random_full_range();
    test_random_clustered();

    wait_for_drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
